// ===== rtl/egcd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package egcd_pkg;

   localparam int PIXEL_BITS    = 16;
   localparam int MAX_WIDTH     = 4096;
   localparam int MAX_HEIGHT    = 4096;
   localparam int COL_BITS      = $clog2(MAX_WIDTH);
   localparam int ROW_BITS      = $clog2(MAX_HEIGHT);
   localparam int DIM_BITS      = 13;
   localparam int ROW_BANKS     = 8;
   localparam int BANK_BITS     = $clog2(ROW_BANKS);
   localparam int LAG_BITS      = 14;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 13;
   localparam int DIFF_BITS     = PIXEL_BITS + 1;
   localparam int SUM_BITS      = PIXEL_BITS + 3;
   localparam int VAL_BITS      = PIXEL_BITS + 4;

   localparam logic [DIM_BITS-1:0] MIN_DIM   = DIM_BITS'(4);
   localparam logic [DIM_BITS-1:0] LIMIT_W   = DIM_BITS'(MAX_WIDTH);
   localparam logic [DIM_BITS-1:0] LIMIT_H   = DIM_BITS'(MAX_HEIGHT);
   localparam logic [DIM_BITS-1:0] RESET_W   = DIM_BITS'(640);
   localparam logic [DIM_BITS-1:0] RESET_H   = DIM_BITS'(480);
   localparam logic [LAG_BITS-1:0] RESET_LAG = LAG_BITS'(3 * 640 + 2);

   typedef logic [PIXEL_BITS-1:0] pix_type;
   typedef logic [2:0][2:0][PIXEL_BITS-1:0] pix3_type;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_GREEN_PHASE     = 3'd0,
      CSR_RED_COL_OFFSET  = 3'd1,
      CSR_RED_ROW_OFFSET  = 3'd2,
      CSR_BLUE_COL_OFFSET = 3'd3,
      CSR_BLUE_ROW_OFFSET = 3'd4,
      CSR_FRAME_WIDTH     = 3'd5,
      CSR_FRAME_HEIGHT    = 3'd6
   } csr_index_type;

   function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v,
                                                     input logic [DIM_BITS-1:0] hi);
      logic [DIM_BITS-1:0] res;
      if (v < MIN_DIM) begin
         res = MIN_DIM;
      end else if (v > hi) begin
         res = hi;
      end else begin
         res = v;
      end
      return res;
   endfunction

   // edge-directed green: mean across the weaker gradient
   function automatic pix_type green_fn(input logic border, input logic is_green,
                                        input pix_type ctr, input pix_type up,
                                        input pix_type dn, input pix_type lf,
                                        input pix_type rt);
      pix_type             dv;
      pix_type             dh;
      logic [PIXEL_BITS:0] sv;
      logic [PIXEL_BITS:0] sh;
      pix_type             res;
      dv = (dn > up) ? dn - up : up - dn;
      dh = (rt > lf) ? rt - lf : lf - rt;
      sv = {1'b0, up} + {1'b0, dn};
      sh = {1'b0, lf} + {1'b0, rt};
      if (border) begin
         res = '0;
      end else if (is_green) begin
         res = ctr;
      end else if (dh > dv) begin
         res = sv[PIXEL_BITS:1];
      end else begin
         res = sh[PIXEL_BITS:1];
      end
      return res;
   endfunction

   // colour difference over the 2x2 anchor block, window centred on the pixel
   function automatic pix_type chroma_fn(input logic [COL_BITS-1:0] x,
                                         input logic [ROW_BITS-1:0] y,
                                         input logic [DIM_BITS-1:0] w,
                                         input logic [DIM_BITS-1:0] h,
                                         input logic ox, input logic oy,
                                         input pix3_type raw3, input pix3_type g3);
      logic                        ddx;
      logic                        ddy;
      logic [DIM_BITS-1:0]         ax;
      logic [DIM_BITS-1:0]         ay;
      logic signed [DIFF_BITS-1:0] d [3][3];
      logic signed [SUM_BITS-1:0]  sum;
      logic signed [VAL_BITS-1:0]  v;
      pix_type                     res;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            d[r][c] = $signed({1'b0, raw3[r][c]}) - $signed({1'b0, g3[r][c]});
         end
      end
      ddx = x[0] ^ ox;
      ddy = y[0] ^ oy;
      ax  = {1'b0, x} - {{(DIM_BITS-1){1'b0}}, ddx};
      ay  = {1'b0, y} - {{(DIM_BITS-1){1'b0}}, ddy};
      sum = '0;
      case ({ddx, ddy})
         2'b10:   sum = (SUM_BITS'(d[1][0]) + SUM_BITS'(d[1][2])) >>> 1;
         2'b01:   sum = (SUM_BITS'(d[0][1]) + SUM_BITS'(d[2][1])) >>> 1;
         2'b11:   sum = (SUM_BITS'(d[0][0]) + SUM_BITS'(d[0][2]) +
                         SUM_BITS'(d[2][0]) + SUM_BITS'(d[2][2])) >>> 2;
         default: sum = '0;
      endcase
      v = VAL_BITS'(sum) + VAL_BITS'($signed({1'b0, g3[1][1]}));
      if ((ox && x == '0) || (oy && y == '0)) begin
         res = '0;
      end else if ((ax + DIM_BITS'(2) >= w) || (ay + DIM_BITS'(2) >= h)) begin
         res = '0;
      end else if (!ddx && !ddy) begin
         res = raw3[1][1];
      end else if (v[VAL_BITS-1]) begin
         res = '0;
      end else if (|v[VAL_BITS-2:PIXEL_BITS]) begin
         res = '1;
      end else begin
         res = v[PIXEL_BITS-1:0];
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/egcd_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface egcd_req_if;
   logic                            valid;
   logic                            ready;
   logic [egcd_pkg::PIXEL_BITS-1:0] raw_value;
   logic                            is_padding;
   modport source (output valid, output raw_value, output is_padding, input ready);
   modport sink   (input valid, input raw_value, input is_padding, output ready);
endinterface

interface egcd_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [egcd_pkg::PIXEL_BITS-1:0] red_value;
   logic [egcd_pkg::PIXEL_BITS-1:0] green_value;
   logic [egcd_pkg::PIXEL_BITS-1:0] blue_value;
   logic                            frame_end;
   modport source (output valid, output red_value, output green_value, output blue_value,
                   output frame_end, input ready);
   modport sink   (input valid, input red_value, input green_value, input blue_value,
                   input frame_end, output ready);
endinterface

interface egcd_csr_if;
   logic                               valid;
   logic                               ready;
   logic [egcd_pkg::CSR_ADDR_BITS-1:0] index;
   logic [egcd_pkg::CSR_DATA_BITS-1:0] wdata;
   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

// ===== rtl/egcd_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module egcd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/edge_green_color_diff_demosaic.sv =====
`timescale 1ns / 1ps
`default_nettype none

// edge-directed bayer demosaic: raw pixels enter in raster order, one word per clock, and
// one rgb word leaves for each pixel of the frame, 3*width+2 pixels behind the input;
// padding words push out the tail of a frame once all of its pixels are in. the block
// takes one word every cycle and stalls only when the result register is full and not
// taken; a pixel released by a word passes through the ram read, window shift, green
// stage and colour stage registers. raw rows live in eight single-port-write banks, one
// per row modulo eight, so the five rows of the 5x5 window are read together; each
// read fetches the column two pixels ahead of the output, running into the next row near
// a row end, and the first two columns of a frame are fetched while row three comes in.
// frame size is sampled on the first real pixel of a frame and saturated to 4..4096; the
// phase and offset registers act live. ram entries not yet written in the current frame
// only ever feed border or uncovered pixels, so the line store needs no clearing after
// reset

module edge_green_color_diff_demosaic (
   input logic        clock,
   input logic        reset,
   egcd_req_if.sink   req_port,
   egcd_rsp_if.source rsp_port,
   egcd_csr_if.sink   csr_port
);

   localparam int PB = egcd_pkg::PIXEL_BITS;
   localparam int CB = egcd_pkg::COL_BITS;
   localparam int RB = egcd_pkg::ROW_BITS;
   localparam int DB = egcd_pkg::DIM_BITS;
   localparam int LB = egcd_pkg::LAG_BITS;
   localparam int NB = egcd_pkg::ROW_BANKS;
   localparam int BB = egcd_pkg::BANK_BITS;

   // configuration registers
   logic          green_phase_ff;
   logic          red_col_ff;
   logic          red_row_ff;
   logic          blue_col_ff;
   logic          blue_row_ff;
   logic [DB-1:0] frame_width_ff;
   logic [DB-1:0] frame_height_ff;

   assign csr_port.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         green_phase_ff  <= 1'b0;
         red_col_ff      <= 1'b1;
         red_row_ff      <= 1'b0;
         blue_col_ff     <= 1'b0;
         blue_row_ff     <= 1'b1;
         frame_width_ff  <= egcd_pkg::RESET_W;
         frame_height_ff <= egcd_pkg::RESET_H;
      end else if (csr_port.valid) begin
         unique case (egcd_pkg::csr_index_type'(csr_port.index))
            egcd_pkg::CSR_GREEN_PHASE:     green_phase_ff  <= csr_port.wdata[0];
            egcd_pkg::CSR_RED_COL_OFFSET:  red_col_ff      <= csr_port.wdata[0];
            egcd_pkg::CSR_RED_ROW_OFFSET:  red_row_ff      <= csr_port.wdata[0];
            egcd_pkg::CSR_BLUE_COL_OFFSET: blue_col_ff     <= csr_port.wdata[0];
            egcd_pkg::CSR_BLUE_ROW_OFFSET: blue_row_ff     <= csr_port.wdata[0];
            egcd_pkg::CSR_FRAME_WIDTH:     frame_width_ff  <= csr_port.wdata;
            egcd_pkg::CSR_FRAME_HEIGHT:    frame_height_ff <= csr_port.wdata;
            default: ;
         endcase
      end
   end

   // frame bookkeeping
   logic [DB-1:0] act_w_ff;
   logic [DB-1:0] act_h_ff;
   logic [LB-1:0] lag_ff;
   logic          busy_ff;
   logic          in_done_ff;
   logic [CB-1:0] in_x_ff;
   logic [RB-1:0] in_y_ff;
   logic [LB-1:0] pend_ff;   // pixels in minus pixels out
   logic [CB-1:0] out_x_ff;
   logic [RB-1:0] out_y_ff;

   logic          rsp_valid_ff;
   logic          adv;
   logic          accept;
   logic          pad;
   logic          start;
   logic [DB-1:0] w_clamp;
   logic [DB-1:0] h_clamp;
   logic [DB-1:0] w_use;
   logic [DB-1:0] h_use;
   logic          write;
   logic          row_wrap_in;
   logic          last_in;
   logic          in_done_in;
   logic [LB-1:0] pend_in;
   logic          fire;
   logic          row_wrap_out;
   logic          out_last;
   logic [LB-1:0] lag_in;

   // whole pipe moves together; held only while the result waits
   assign adv            = !rsp_valid_ff || rsp_port.ready;
   assign req_port.ready = adv;
   assign accept         = req_port.valid && adv;
   assign pad            = req_port.is_padding;
   assign start          = !pad && !busy_ff;

   assign w_clamp = egcd_pkg::clamp_dim(frame_width_ff, egcd_pkg::LIMIT_W);
   assign h_clamp = egcd_pkg::clamp_dim(frame_height_ff, egcd_pkg::LIMIT_H);
   assign w_use   = start ? w_clamp : act_w_ff;
   assign h_use   = start ? h_clamp : act_h_ff;
   assign lag_in  = LB'({w_clamp, 1'b0}) + LB'(w_clamp) + LB'(2);

   // a real word after the frame is complete only flushes
   assign write       = accept && !pad && !in_done_ff;
   assign row_wrap_in = ({1'b0, in_x_ff} == w_use - DB'(1));
   assign last_in     = row_wrap_in && ({1'b0, in_y_ff} == h_use - DB'(1));
   assign in_done_in  = in_done_ff || (write && last_in);
   assign pend_in     = pend_ff + LB'(write);
   assign fire        = accept && (in_done_in || (pend_in > lag_ff));

   assign row_wrap_out = ({1'b0, out_x_ff} == act_w_ff - DB'(1));
   assign out_last     = row_wrap_out && ({1'b0, out_y_ff} == act_h_ff - DB'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         act_w_ff   <= egcd_pkg::RESET_W;
         act_h_ff   <= egcd_pkg::RESET_H;
         lag_ff     <= egcd_pkg::RESET_LAG;
         busy_ff    <= 1'b0;
         in_done_ff <= 1'b0;
         in_x_ff    <= '0;
         in_y_ff    <= '0;
         pend_ff    <= '0;
         out_x_ff   <= '0;
         out_y_ff   <= '0;
      end else if (accept) begin
         if (start) begin
            act_w_ff <= w_clamp;
            act_h_ff <= h_clamp;
            lag_ff   <= lag_in;
         end
         if (write) begin
            busy_ff    <= 1'b1;
            in_done_ff <= in_done_in;
            if (row_wrap_in) begin
               in_x_ff <= '0;
               in_y_ff <= in_y_ff + RB'(1);
            end else begin
               in_x_ff <= in_x_ff + CB'(1);
            end
         end
         pend_ff <= pend_in - LB'(fire);
         if (fire) begin
            if (row_wrap_out) begin
               out_x_ff <= '0;
               out_y_ff <= out_y_ff + RB'(1);
            end else begin
               out_x_ff <= out_x_ff + CB'(1);
            end
            // last pixel out: back to an empty frame
            if (out_last) begin
               busy_ff    <= 1'b0;
               in_done_ff <= 1'b0;
               in_x_ff    <= '0;
               in_y_ff    <= '0;
               pend_ff    <= '0;
               out_x_ff   <= '0;
               out_y_ff   <= '0;
            end
         end
      end
   end

   // line store: one bank per row modulo eight; each read takes the column two pixels
   // ahead of the output, in the rows around that pixel's row
   logic [PB-1:0] bank_rd [NB];
   logic [DB-1:0] ahead;
   logic [DB-1:0] ahead_wrap;
   logic          rd_wrap;
   logic          prime;
   logic          rd_en;
   logic [CB-1:0] rd_col;
   logic [BB-1:0] rd_bank;

   assign ahead      = {1'b0, out_x_ff} + DB'(2);
   assign ahead_wrap = ahead - act_w_ff;
   assign rd_wrap    = (ahead >= act_w_ff);
   // columns 0 and 1 of row 0 fetched early, while row three comes in
   assign prime      = write && (in_y_ff == RB'(3)) && (in_x_ff[CB-1:1] == '0);
   assign rd_en      = fire || prime;
   assign rd_col     = prime ? in_x_ff : (rd_wrap ? ahead_wrap[CB-1:0] : ahead[CB-1:0]);
   assign rd_bank    = prime ? BB'(0) : (out_y_ff[BB-1:0] + BB'(rd_wrap));

   for (genvar gb = 0; gb < NB; gb++) begin : g_bank
      egcd_ram #(
         .WIDTH(PB),
         .DEPTH(egcd_pkg::MAX_WIDTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (write && (in_y_ff[BB-1:0] == BB'(gb))),
         .wr_addr (in_x_ff),
         .wr_data (req_port.raw_value),
         .rd_en   (rd_en),
         .rd_addr (rd_col),
         .rd_data (bank_rd[gb])
      );
   end

   // stage 1: ram data arriving
   logic          s1_v_ff;
   logic          s1_sh_ff;
   logic [BB-1:0] s1_bank_ff;
   logic [CB-1:0] s1_x_ff;
   logic [RB-1:0] s1_y_ff;
   logic [DB-1:0] s1_w_ff;
   logic [DB-1:0] s1_h_ff;
   logic          s1_end_ff;

   // stage 2: 5x5 raw window, row 0 is y-2, column 4 is x+2
   logic [4:0][4:0][PB-1:0] win_ff;
   logic [4:0][PB-1:0]      new_col;
   logic          s2_v_ff;
   logic [CB-1:0] s2_x_ff;
   logic [RB-1:0] s2_y_ff;
   logic [DB-1:0] s2_w_ff;
   logic [DB-1:0] s2_h_ff;
   logic          s2_end_ff;

   for (genvar gr = 0; gr < 5; gr++) begin : g_newcol
      logic [BB-1:0] sel;
      assign sel         = s1_bank_ff + BB'(gr + NB - 2);
      assign new_col[gr] = bank_rd[sel];
   end

   // green over the 3x3 around the pixel, raw alongside
   egcd_pkg::pix3_type green_s2;
   egcd_pkg::pix3_type raw_s2;

   for (genvar gr = 0; gr < 3; gr++) begin : g_grow
      for (genvar gc = 0; gc < 3; gc++) begin : g_gcol
         logic [DB-1:0] xp;
         logic [DB-1:0] yp;
         logic          brd;
         logic          isg;
         assign xp  = {1'b0, s2_x_ff} + DB'(gc) - DB'(1);
         assign yp  = {1'b0, s2_y_ff} + DB'(gr) - DB'(1);
         assign brd = (xp == '0) || (yp == '0) ||
                      ({1'b0, xp} + (DB+1)'(1) >= {1'b0, s2_w_ff}) ||
                      ({1'b0, yp} + (DB+1)'(1) >= {1'b0, s2_h_ff});
         assign isg = ((xp[0] ^ yp[0]) == green_phase_ff);
         assign green_s2[gr][gc] = egcd_pkg::green_fn(brd, isg,
                                      win_ff[gr+1][gc+1], win_ff[gr][gc+1],
                                      win_ff[gr+2][gc+1], win_ff[gr+1][gc],
                                      win_ff[gr+1][gc+2]);
         assign raw_s2[gr][gc] = win_ff[gr+1][gc+1];
      end
   end

   // stage 3: greens registered, colour differences next
   logic               s3_v_ff;
   logic [CB-1:0]      s3_x_ff;
   logic [RB-1:0]      s3_y_ff;
   logic [DB-1:0]      s3_w_ff;
   logic [DB-1:0]      s3_h_ff;
   logic               s3_end_ff;
   egcd_pkg::pix3_type g3_ff;
   egcd_pkg::pix3_type raw3_ff;

   logic [PB-1:0] red_s3;
   logic [PB-1:0] blue_s3;

   assign red_s3  = egcd_pkg::chroma_fn(s3_x_ff, s3_y_ff, s3_w_ff, s3_h_ff,
                                        red_col_ff, red_row_ff, raw3_ff, g3_ff);
   assign blue_s3 = egcd_pkg::chroma_fn(s3_x_ff, s3_y_ff, s3_w_ff, s3_h_ff,
                                        blue_col_ff, blue_row_ff, raw3_ff, g3_ff);

   // result register
   logic [PB-1:0] red_ff;
   logic [PB-1:0] green_ff;
   logic [PB-1:0] blue_ff;
   logic          end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff      <= 1'b0;
         s1_sh_ff     <= 1'b0;
         s2_v_ff      <= 1'b0;
         s3_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff      <= fire;
         s1_sh_ff     <= rd_en;
         s2_v_ff      <= s1_v_ff;
         s3_v_ff      <= s2_v_ff;
         rsp_valid_ff <= s3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (rd_en) begin
            s1_bank_ff <= rd_bank;
         end
         if (fire) begin
            s1_x_ff   <= out_x_ff;
            s1_y_ff   <= out_y_ff;
            s1_w_ff   <= act_w_ff;
            s1_h_ff   <= act_h_ff;
            s1_end_ff <= out_last;
         end
         // every read, early fetches included, moves the window on one column
         if (s1_sh_ff) begin
            for (int r = 0; r < 5; r++) begin
               win_ff[r] <= {new_col[r], win_ff[r][4:1]};
            end
         end
         if (s1_v_ff) begin
            s2_x_ff   <= s1_x_ff;
            s2_y_ff   <= s1_y_ff;
            s2_w_ff   <= s1_w_ff;
            s2_h_ff   <= s1_h_ff;
            s2_end_ff <= s1_end_ff;
         end
         if (s2_v_ff) begin
            g3_ff     <= green_s2;
            raw3_ff   <= raw_s2;
            s3_x_ff   <= s2_x_ff;
            s3_y_ff   <= s2_y_ff;
            s3_w_ff   <= s2_w_ff;
            s3_h_ff   <= s2_h_ff;
            s3_end_ff <= s2_end_ff;
         end
         if (s3_v_ff) begin
            red_ff   <= red_s3;
            green_ff <= g3_ff[1][1];
            blue_ff  <= blue_s3;
            end_ff   <= s3_end_ff;
         end
      end
   end

   assign rsp_port.valid       = rsp_valid_ff;
   assign rsp_port.red_value   = red_ff;
   assign rsp_port.green_value = green_ff;
   assign rsp_port.blue_value  = blue_ff;
   assign rsp_port.frame_end   = end_ff;

endmodule

`default_nettype wire

// ===== test/edge_green_color_diff_demosaic_test.sv =====
`timescale 1ns / 1ps
`default_nettype none

module edge_green_color_diff_demosaic_test;

   localparam logic [egcd_pkg::CSR_ADDR_BITS-1:0] CSR_SPARE = 3'd7;   // no register behind it
   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_CYCLES = 12;                        // pipeline is four deep

   typedef struct {
      egcd_pkg::pix_type raw;
      logic              pad;
   } bayer_word_type;

   typedef struct {
      egcd_pkg::pix_type red;
      egcd_pkg::pix_type green;
      egcd_pkg::pix_type blue;
      logic              fend;
   } rgb_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   egcd_req_if req_bus ();
   egcd_rsp_if rsp_bus ();
   egcd_csr_if csr_bus ();

   edge_green_color_diff_demosaic uut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus),
      .csr_port (csr_bus)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // words waiting to be offered, and rgb words the block owes us
   bayer_word_type pixel_queue [$];
   rgb_word_type   rgb_expected [$];

   int errors = 0;
   int cycle_count = 0;
   int words_sent = 0;
   int pixels_seen = 0;
   int frames_seen = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;

   // shadow of the block: raw rows by row mod 8, frame counters, registers
   egcd_pkg::pix_type raw_rows [8][egcd_pkg::MAX_WIDTH];
   int          in_cnt, out_cnt, cur_w, cur_h;
   logic        sh_phase, sh_rox, sh_roy, sh_box, sh_boy;
   logic [12:0] sh_width, sh_height;

   task automatic report(input string what, input int got, input int want);
      $display("mismatch at pixel %0d: %s got %0d want %0d", pixels_seen, what, got, want);
      errors++;
   endtask

   task automatic queue_word(input bayer_word_type wd);
      pixel_queue = {pixel_queue, wd};
   endtask

   task automatic owe_rgb(input rgb_word_type px);
      rgb_expected = {rgb_expected, px};
   endtask

   function automatic int raw_at(input int x, input int y);
      return raw_rows[y & 7][x % egcd_pkg::MAX_WIDTH];
   endfunction

   function automatic int green_of(input int x, input int y);
      int up, dn, lf, rt, dv, dh;
      if (x == 0 || y == 0 || x + 1 >= cur_w || y + 1 >= cur_h) return 0;
      if (((x + y) & 1) == int'(sh_phase)) return raw_at(x, y);
      up = raw_at(x, y - 1);
      dn = raw_at(x, y + 1);
      lf = raw_at(x - 1, y);
      rt = raw_at(x + 1, y);
      dv = dn > up ? dn - up : up - dn;
      dh = rt > lf ? rt - lf : lf - rt;
      if (dh > dv) return (up + dn) >> 1;
      return (lf + rt) >> 1;
   endfunction

   function automatic int colour_diff(input int x, input int y);
      return raw_at(x, y) - green_of(x, y);
   endfunction

   // anchor value, or mean of colour differences over the anchors plus local green
   function automatic int chroma_of(input int x, input int y, input int ox, input int oy);
      int ddx, ddy, ax, ay, v;
      if (x < ox || y < oy) return 0;
      ddx = (x - ox) & 1;
      ddy = (y - oy) & 1;
      ax = x - ddx;
      ay = y - ddy;
      if (ax + 2 >= cur_w || ay + 2 >= cur_h) return 0;
      if (!ddx && !ddy) return raw_at(ax, ay);
      if (ddx && !ddy)
         v = (colour_diff(ax, ay) + colour_diff(ax + 2, ay)) >>> 1;
      else if (!ddx && ddy)
         v = (colour_diff(ax, ay) + colour_diff(ax, ay + 2)) >>> 1;
      else
         v = (colour_diff(ax, ay) + colour_diff(ax + 2, ay) +
              colour_diff(ax, ay + 2) + colour_diff(ax + 2, ay + 2)) >>> 2;
      v += green_of(x, y);
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      return v;
   endfunction

   function automatic int clamp_size(input int v);
      return v < 4 ? 4 : (v > 4096 ? 4096 : v);
   endfunction

   task automatic demosaic_step(input bayer_word_type wd);
      int total, lag, x, y;
      rgb_word_type px;
      if (!wd.pad && in_cnt == 0 && out_cnt == 0) begin
         cur_w = clamp_size(sh_width);
         cur_h = clamp_size(sh_height);
      end
      total = cur_w * cur_h;
      lag = 3 * cur_w + 2;
      if (!wd.pad && in_cnt < total) begin
         raw_rows[(in_cnt / cur_w) & 7][in_cnt % cur_w] = wd.raw;
         in_cnt++;
      end
      if (in_cnt == total || in_cnt - out_cnt > lag) begin
         x = out_cnt % cur_w;
         y = out_cnt / cur_w;
         px.red = egcd_pkg::pix_type'(chroma_of(x, y, sh_rox, sh_roy));
         px.green = egcd_pkg::pix_type'(green_of(x, y));
         px.blue = egcd_pkg::pix_type'(chroma_of(x, y, sh_box, sh_boy));
         px.fend = (out_cnt + 1 == total);
         owe_rgb(px);
         out_cnt++;
         if (out_cnt >= total) begin
            out_cnt = 0;
            in_cnt = 0;
         end
      end
   endtask

   task automatic shadow_write(input logic [egcd_pkg::CSR_ADDR_BITS-1:0] idx,
                               input logic [egcd_pkg::CSR_DATA_BITS-1:0] val);
      case (idx)
         egcd_pkg::CSR_GREEN_PHASE:     sh_phase = val[0];
         egcd_pkg::CSR_RED_COL_OFFSET:  sh_rox = val[0];
         egcd_pkg::CSR_RED_ROW_OFFSET:  sh_roy = val[0];
         egcd_pkg::CSR_BLUE_COL_OFFSET: sh_box = val[0];
         egcd_pkg::CSR_BLUE_ROW_OFFSET: sh_boy = val[0];
         egcd_pkg::CSR_FRAME_WIDTH:     sh_width = val;
         egcd_pkg::CSR_FRAME_HEIGHT:    sh_height = val;
         default: ;
      endcase
   endtask

   // idling: about 19 in 100, none at all in a stretch early in the run
   function automatic bit take_break();
      if (cycle_count > 600 && cycle_count < 1400) return 1'b0;
      return $urandom_range(99) < 19;
   endfunction

   // driver: offers the queued words, feeds the shadow on every accepted word
   always @(posedge clock) begin
      bayer_word_type wd;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            wd.raw = req_bus.raw_value;
            wd.pad = req_bus.is_padding;
            demosaic_step(wd);
            words_sent++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (pixel_queue.size() > 0 && !take_break()) begin
               wd = pixel_queue.pop_front();
               req_bus.valid <= 1'b1;
               req_bus.raw_value <= wd.raw;
               req_bus.is_padding <= wd.pad;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   initial begin
      req_bus.raw_value = '0;
      req_bus.is_padding = 1'b0;
      req_bus.valid = 1'b0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = '0;
      csr_bus.wdata = '0;
   end

   // long receiver hold-off, once, while the sender still has words to offer
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end else if (!hold_done && pixels_seen >= 300 && pixel_queue.size() > 16) begin
         hold_left <= 400;
         hold_done <= 1'b1;
      end
   end

   // monitor: every rgb word against the oldest expectation
   always @(posedge clock) begin
      rgb_word_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (rgb_expected.size() == 0) begin
               report("unexpected rgb word", 1, 0);
            end else begin
               want = rgb_expected.pop_front();
               if (rsp_bus.red_value !== want.red)
                  report("red", rsp_bus.red_value, want.red);
               if (rsp_bus.green_value !== want.green)
                  report("green", rsp_bus.green_value, want.green);
               if (rsp_bus.blue_value !== want.blue)
                  report("blue", rsp_bus.blue_value, want.blue);
               if (rsp_bus.frame_end !== want.fend)
                  report("frame_end", rsp_bus.frame_end, want.fend);
               if (want.fend) frames_seen++;
            end
            pixels_seen++;
         end
         rsp_bus.ready <= (hold_left == 0) && !take_break();
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout with %0d rgb words outstanding", rgb_expected.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic csr_write(input logic [egcd_pkg::CSR_ADDR_BITS-1:0] idx,
                            input logic [egcd_pkg::CSR_DATA_BITS-1:0] val);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.wdata <= val;
      do @(posedge clock); while (!(csr_bus.valid && csr_bus.ready));
      shadow_write(idx, val);
      csr_bus.valid <= 1'b0;
   endtask

   // sender pauses until the block has handed back everything it owes
   task automatic wait_idle();
      while (pixel_queue.size() > 0 || req_bus.valid || rgb_expected.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_layout(input logic ph, input logic rox, input logic roy,
                             input logic box, input logic boy,
                             input int w, input int h);
      csr_write(egcd_pkg::CSR_GREEN_PHASE, 13'(ph));
      csr_write(egcd_pkg::CSR_RED_COL_OFFSET, 13'(rox));
      csr_write(egcd_pkg::CSR_RED_ROW_OFFSET, 13'(roy));
      csr_write(egcd_pkg::CSR_BLUE_COL_OFFSET, 13'(box));
      csr_write(egcd_pkg::CSR_BLUE_ROW_OFFSET, 13'(boy));
      csr_write(egcd_pkg::CSR_FRAME_WIDTH, 13'(w));
      csr_write(egcd_pkg::CSR_FRAME_HEIGHT, 13'(h));
   endtask

   function automatic egcd_pkg::pix_type pick_value(input int style, input int n);
      case (style)
         0: return (n & 1) ? 16'hFFFF : 16'h0000;
         1: return ($urandom_range(99) < 30) ? ($urandom_range(1) ? 16'hFFFF : 16'h0)
                                             : egcd_pkg::pix_type'($urandom);
         default: return egcd_pkg::pix_type'($urandom);
      endcase
   endfunction

   // one frame: pixels, with some stray padding when noisy, then exactly the flush tail,
   // part of which, when noisy, is real words that the block treats as padding
   task automatic queue_frame(input int w_reg, input int h_reg, input int style,
                              input bit noisy);
      int w, h;
      bayer_word_type wd;
      w = clamp_size(w_reg);
      h = clamp_size(h_reg);
      for (int n = 0; n < w * h; n++) begin
         if (noisy && $urandom_range(99) < 5) begin
            wd.raw = egcd_pkg::pix_type'($urandom);
            wd.pad = 1'b1;
            queue_word(wd);
         end
         wd.raw = pick_value(style, n + n / w);
         wd.pad = 1'b0;
         queue_word(wd);
      end
      for (int n = 0; n < 3 * w + 2; n++) begin
         wd.raw = egcd_pkg::pix_type'($urandom);
         wd.pad = noisy ? ($urandom_range(3) != 0) : 1'b1;
         queue_word(wd);
      end
   endtask

   initial begin
      bayer_word_type wd;
      int w, h;
      foreach (raw_rows[r, c]) raw_rows[r][c] = '0;
      in_cnt = 0;
      out_cnt = 0;
      cur_w = 640;
      cur_h = 480;
      sh_phase = 1'b0; sh_rox = 1'b1; sh_roy = 1'b0; sh_box = 1'b0; sh_boy = 1'b1;
      sh_width = 13'd640;
      sh_height = 13'd480;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: padding while idle, smallest frame, checkerboard extremes
      csr_write(CSR_SPARE, 13'h1FFF);
      csr_write(egcd_pkg::CSR_FRAME_WIDTH, 13'd4);
      csr_write(egcd_pkg::CSR_FRAME_HEIGHT, 13'd4);
      wd.raw = 16'hFFFF;
      wd.pad = 1'b1;
      queue_word(wd);
      queue_frame(4, 4, 0, 1'b1);
      wait_idle();
      // undersized registers saturate up to 4, every offset flipped
      set_layout(1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 0, 3);
      queue_frame(0, 3, 1, 1'b1);
      wait_idle();
      // a wider frame with clean padding
      set_layout(1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 40, 5);
      queue_frame(40, 5, 1, 1'b0);
      wait_idle();

      // random frames, mostly small, every register written between frames
      while (words_sent < 1300) begin
         w = ($urandom_range(9) == 0) ? $urandom_range(3) : $urandom_range(12, 4);
         h = ($urandom_range(9) == 0) ? $urandom_range(3) : $urandom_range(8, 4);
         set_layout($urandom_range(1), $urandom_range(1), $urandom_range(1),
                    $urandom_range(1), $urandom_range(1), w, h);
         queue_frame(w, h, $urandom_range(2), 1'b1);
         wait_idle();
      end

      $display("sent %0d words, checked %0d rgb words over %0d frames", words_sent,
               pixels_seen, frames_seen);
      $display("frames 4 to 40 wide, undersized size registers, all phase and offset settings");
      if (errors == 0 && rgb_expected.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches, %0d rgb words missing", errors, rgb_expected.size());
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

`default_nettype wire
